// ===== src/bpa_pkg.sv =====
// Shared types and constants of the bitmap page allocator.
`timescale 1ns / 1ps

package bpa_pkg;

    localparam int ADDR_W     = 48;
    localparam int CNT_W      = 13;
    localparam int PAGE_SHIFT = 12;
    localparam int WORD_MAX   = 64;

    typedef logic [1:0] cmd_t;
    localparam cmd_t CMD_ALLOC = 2'd0;
    localparam cmd_t CMD_FREE  = 2'd1;
    localparam cmd_t CMD_INIT  = 2'd2;

    typedef logic [1:0] status_t;
    localparam status_t STAT_OK      = 2'd0;
    localparam status_t STAT_REFUSED = 2'd1;
    localparam status_t STAT_IGNORED = 2'd2;

    typedef logic [0:0] reg_idx_t;
    localparam reg_idx_t REG_REGION_BASE = 1'd0;
    localparam reg_idx_t REG_PAGE_LIMIT  = 1'd1;

    typedef struct packed {
        cmd_t              command;
        logic [CNT_W-1:0]  page_count_req;
        logic [ADDR_W-1:0] address;
    } req_item_t;

    typedef struct packed {
        status_t           status;
        logic [ADDR_W-1:0] alloc_address;
        logic [CNT_W-1:0]  pages_free;
        logic [CNT_W-1:0]  pages_used;
    } rsp_item_t;

    typedef struct packed {
        reg_idx_t          index;
        logic [ADDR_W-1:0] wdata;
    } cfg_item_t;

    typedef struct packed {
        logic             found;
        logic             from_carry;
        logic [CNT_W-1:0] run_out;
    } scan_res_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_SCAN,
        S_FCHK,
        S_MARK,
        S_DONE
    } state_t;

endpackage

// ===== src/bpa_stream_if.sv =====
// Valid/ready channel carrying one item of a given payload type.
`timescale 1ns / 1ps

interface bpa_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/bpa_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module bpa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/bpa_scan.sv =====
// Searches one bitmap word for the first free run, continuing a run from earlier words.
`timescale 1ns / 1ps

module bpa_scan #(
    parameter int WB = 64
) (
    input  logic [WB-1:0]             in_use,
    input  logic [bpa_pkg::CNT_W-1:0] need_n,
    input  logic [bpa_pkg::CNT_W-1:0] run_in,
    output bpa_pkg::scan_res_t        res,
    output logic [$clog2(WB)-1:0]     offset
);

    localparam int OW = $clog2(WB);
    localparam int CW = bpa_pkg::CNT_W;

    logic [WB-1:0] free_bits;
    logic [WB-1:0] win_mask;
    logic [WB-1:0] win_ok;
    logic [OW:0]   trail;
    logic [OW:0]   lead;
    logic [OW:0]   shamt;
    logic [CW-1:0] need;
    logic          hit_carry;
    logic          hit_local;
    logic [OW-1:0] first_s;

    always_comb
    begin
        free_bits = ~in_use;

        // Free pages counted from bit zero up, and from the top bit down.
        trail = (OW + 1)'(WB);
        for (int i = WB - 1; i >= 0; i--)
        begin
            if (in_use[i])
            begin
                trail = (OW + 1)'(i);
            end
        end
        lead = (OW + 1)'(WB);
        for (int i = 0; i < WB; i++)
        begin
            if (in_use[i])
            begin
                lead = (OW + 1)'(WB - 1 - i);
            end
        end

        // A run carried in from earlier words ends first, so it wins.
        need      = need_n - run_in;
        hit_carry = (need <= CW'(trail));

        shamt    = (OW + 1)'(WB) - (OW + 1)'(need_n);
        win_mask = {WB{1'b1}} >> shamt;
        for (int s = 0; s < WB; s++)
        begin
            win_ok[s] = (((free_bits >> s) & win_mask) == win_mask);
        end
        hit_local = (need_n != '0) && (need_n <= CW'(WB)) && (|win_ok);

        first_s = '0;
        for (int s = WB - 1; s >= 0; s--)
        begin
            if (win_ok[s])
            begin
                first_s = OW'(s);
            end
        end

        res.found      = hit_carry || hit_local;
        res.from_carry = hit_carry;
        res.run_out    = (trail == (OW + 1)'(WB)) ? run_in + CW'(WB) : CW'(lead);
        offset         = first_s;
    end

endmodule

// ===== src/bitmap_page_allocator.sv =====
// Top level of the bitmap first-fit page allocator.
//
//  channel  role    payload                                        item moved when
//  req      sink    command, page_count_req, address               valid && ready
//  rsp      source  status, alloc_address, pages_free, pages_used  valid && ready
//  cfg      sink    index (0 region_base, 1 page_limit), wdata     valid && ready
//
// The bitmap sits in one RAM of 64-bit words; every pass moves one word per cycle.
// Initialize writes every word of the bitmap. Allocate searches the words that hold
// managed pages, then marks the words spanned by the run. Free checks its request, then
// clears the words spanned. One item is worked at a time; the result register lets the
// next item be taken while a result waits. After reset the block manages no pages until
// an initialize item arrives.
`timescale 1ns / 1ps

module bitmap_page_allocator #(
    parameter int MAX_PAGE_COUNT = 4096
) (
    input  logic         clk,
    input  logic         rst_n,
    bpa_stream_if.sink   req,
    bpa_stream_if.source rsp,
    bpa_stream_if.sink   cfg
);

    localparam int AW    = bpa_pkg::ADDR_W;
    localparam int CW    = bpa_pkg::CNT_W;
    localparam int PS    = bpa_pkg::PAGE_SHIFT;
    localparam int PGW   = AW - PS;
    localparam int WB    = (MAX_PAGE_COUNT < bpa_pkg::WORD_MAX) ? MAX_PAGE_COUNT
                                                                 : bpa_pkg::WORD_MAX;
    localparam int WORDS = (MAX_PAGE_COUNT + WB - 1) / WB;
    localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int OW    = $clog2(WB);
    localparam int IW    = $clog2(MAX_PAGE_COUNT);
    localparam int SW    = ((IW > CW) ? IW : CW) + 1;

    bpa_pkg::state_t  state_reg, state_next;
    logic             rsp_valid_reg, rsp_valid_next;
    logic             dv_reg, dv_next;
    logic [AW-1:0]    cfg_base_reg, cfg_base_next;
    logic [CW-1:0]    cfg_limit_reg, cfg_limit_next;
    logic [AW-1:0]    base_reg, base_next;
    logic [CW-1:0]    managed_reg, managed_next;
    logic [CW-1:0]    free_reg, free_next;

    bpa_pkg::rsp_item_t rsp_data_reg, rsp_data_next;
    bpa_pkg::cmd_t      cmd_reg, cmd_next;
    bpa_pkg::status_t   status_reg, status_next;
    logic [CW-1:0]      n_reg, n_next;
    logic [AW-1:0]      addr_reg, addr_next;
    logic [CW-1:0]      run_reg, run_next;
    logic [WAW:0]       rd_word_reg, rd_word_next;
    logic [WAW-1:0]     last_word_reg, last_word_next;
    logic [WAW-1:0]     dword_reg, dword_next;
    logic [IW-1:0]      start_reg, start_next;
    logic [IW-1:0]      end_reg, end_next;

    logic               ram_we;
    logic [WAW-1:0]     ram_waddr;
    logic [WB-1:0]      ram_wdata;
    logic               ram_re;
    logic [WB-1:0]      ram_rdata;

    bpa_pkg::scan_res_t scan_res;
    logic [OW-1:0]      scan_off;

    logic [CW-1:0]      lim_sat;
    logic [WB-1:0]      init_pattern;
    logic [SW-1:0]      init_wbase;
    logic [IW-1:0]      word_base;
    logic [IW-1:0]      found_start;
    logic [IW-1:0]      found_end;
    logic [AW-1:0]      free_off;
    logic [PGW-1:0]     free_pg;
    logic               free_ok;
    logic [IW-1:0]      free_end;
    logic [OW-1:0]      mask_lo;
    logic [OW-1:0]      mask_hi;
    logic [WB-1:0]      range_mask;
    logic               issue;

    bpa_ram #(
        .WIDTH (WB),
        .DEPTH (WORDS)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_word_reg[WAW-1:0]),
        .rdata (ram_rdata)
    );

    bpa_scan #(
        .WB (WB)
    ) u_scan (
        .in_use (ram_rdata),
        .need_n (n_reg),
        .run_in (run_reg),
        .res    (scan_res),
        .offset (scan_off)
    );

    assign req.ready = (state_reg == bpa_pkg::S_IDLE);
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;
    assign cfg.ready = 1'b1;

    // Datapath helpers shared by several states.
    always_comb
    begin
        lim_sat = (32'(cfg_limit_reg) > MAX_PAGE_COUNT) ? CW'(MAX_PAGE_COUNT) : cfg_limit_reg;

        // Init writes pages below the limit as free and the rest as in use.
        init_wbase = SW'(rd_word_reg[WAW-1:0]) << OW;
        if (init_wbase >= SW'(managed_reg))
        begin
            init_pattern = '1;
        end
        else if (SW'(managed_reg) - init_wbase >= SW'(WB))
        begin
            init_pattern = '0;
        end
        else
        begin
            init_pattern = {WB{1'b1}} << OW'(SW'(managed_reg) - init_wbase);
        end

        word_base   = IW'(dword_reg) << OW;
        found_start = scan_res.from_carry ? word_base - IW'(run_reg) : word_base + IW'(scan_off);
        found_end   = IW'(SW'(found_start) + SW'(n_reg) - SW'(1));

        free_off = addr_reg - base_reg;
        free_pg  = free_off[AW-1:PS];
        free_ok  = (addr_reg != '0) && (n_reg != '0) && (addr_reg >= base_reg)
                   && (free_pg < PGW'(managed_reg))
                   && (SW'(free_pg) + SW'(n_reg) <= SW'(managed_reg));
        free_end = IW'(SW'(free_pg) + SW'(n_reg) - SW'(1));

        mask_lo    = (dword_reg == WAW'(start_reg >> OW)) ? start_reg[OW-1:0] : '0;
        mask_hi    = (dword_reg == last_word_reg) ? end_reg[OW-1:0] : OW'(WB - 1);
        range_mask = ({WB{1'b1}} << mask_lo) & ({WB{1'b1}} >> (OW'(WB - 1) - mask_hi));

        issue = (rd_word_reg <= {1'b0, last_word_reg});
    end

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_data_next  = rsp_data_reg;
        dv_next        = 1'b0;
        cfg_base_next  = cfg_base_reg;
        cfg_limit_next = cfg_limit_reg;
        base_next      = base_reg;
        managed_next   = managed_reg;
        free_next      = free_reg;
        cmd_next       = cmd_reg;
        status_next    = status_reg;
        n_next         = n_reg;
        addr_next      = addr_reg;
        run_next       = run_reg;
        rd_word_next   = rd_word_reg;
        last_word_next = last_word_reg;
        dword_next     = dword_reg;
        start_next     = start_reg;
        end_next       = end_reg;
        ram_we         = 1'b0;
        ram_waddr      = dword_reg;
        ram_wdata      = '0;
        ram_re         = 1'b0;

        if (cfg.valid)
        begin
            unique case (cfg.data.index)
                bpa_pkg::REG_REGION_BASE: cfg_base_next  = cfg.data.wdata;
                bpa_pkg::REG_PAGE_LIMIT:  cfg_limit_next = cfg.data.wdata[CW-1:0];
                default:                  cfg_base_next  = cfg_base_reg;
            endcase
        end

        unique case (state_reg)
            bpa_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next     = req.data.command;
                    n_next       = req.data.page_count_req;
                    addr_next    = req.data.address;
                    rd_word_next = '0;
                    run_next     = '0;
                    unique case (req.data.command)
                        bpa_pkg::CMD_INIT:
                        begin
                            managed_next = lim_sat;
                            base_next    = cfg_base_reg;
                            free_next    = lim_sat;
                            state_next   = bpa_pkg::S_INIT;
                        end
                        bpa_pkg::CMD_ALLOC:
                        begin
                            if (req.data.page_count_req == '0
                                || req.data.page_count_req > free_reg)
                            begin
                                status_next = bpa_pkg::STAT_REFUSED;
                                state_next  = bpa_pkg::S_DONE;
                            end
                            else
                            begin
                                last_word_next = WAW'((managed_reg - CW'(1)) >> OW);
                                state_next     = bpa_pkg::S_SCAN;
                            end
                        end
                        bpa_pkg::CMD_FREE:
                        begin
                            state_next = bpa_pkg::S_FCHK;
                        end
                        default:
                        begin
                            status_next = bpa_pkg::STAT_IGNORED;
                            state_next  = bpa_pkg::S_DONE;
                        end
                    endcase
                end
            end

            bpa_pkg::S_INIT:
            begin
                ram_we       = 1'b1;
                ram_waddr    = rd_word_reg[WAW-1:0];
                ram_wdata    = init_pattern;
                rd_word_next = rd_word_reg + 1'b1;
                if (rd_word_reg[WAW-1:0] == WAW'(WORDS - 1))
                begin
                    status_next = bpa_pkg::STAT_OK;
                    state_next  = bpa_pkg::S_DONE;
                end
            end

            bpa_pkg::S_SCAN:
            begin
                // Reads run one word ahead of the search.
                ram_re     = issue;
                dv_next    = issue;
                dword_next = rd_word_reg[WAW-1:0];
                if (issue)
                begin
                    rd_word_next = rd_word_reg + 1'b1;
                end
                if (dv_reg)
                begin
                    if (scan_res.found)
                    begin
                        start_next     = found_start;
                        end_next       = found_end;
                        free_next      = free_reg - n_reg;
                        rd_word_next   = {1'b0, WAW'(found_start >> OW)};
                        last_word_next = WAW'(found_end >> OW);
                        dv_next        = 1'b0;
                        state_next     = bpa_pkg::S_MARK;
                    end
                    else
                    begin
                        run_next = scan_res.run_out;
                        if (dword_reg == last_word_reg)
                        begin
                            dv_next     = 1'b0;
                            status_next = bpa_pkg::STAT_REFUSED;
                            state_next  = bpa_pkg::S_DONE;
                        end
                    end
                end
            end

            bpa_pkg::S_FCHK:
            begin
                if (free_ok)
                begin
                    start_next     = IW'(free_pg);
                    end_next       = free_end;
                    rd_word_next   = {1'b0, WAW'(IW'(free_pg) >> OW)};
                    last_word_next = WAW'(free_end >> OW);
                    state_next     = bpa_pkg::S_MARK;
                end
                else
                begin
                    status_next = bpa_pkg::STAT_IGNORED;
                    state_next  = bpa_pkg::S_DONE;
                end
            end

            bpa_pkg::S_MARK:
            begin
                // Word k is written back while word k + 1 is read, so no two
                // accesses touch the same word in one cycle.
                ram_re     = issue;
                dv_next    = issue;
                dword_next = rd_word_reg[WAW-1:0];
                if (issue)
                begin
                    rd_word_next = rd_word_reg + 1'b1;
                end
                if (dv_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = dword_reg;
                    if (cmd_reg == bpa_pkg::CMD_ALLOC)
                    begin
                        ram_wdata = ram_rdata | range_mask;
                    end
                    else
                    begin
                        ram_wdata = ram_rdata & ~range_mask;
                        free_next = free_reg + CW'($countones(ram_rdata & range_mask));
                    end
                    if (dword_reg == last_word_reg)
                    begin
                        dv_next     = 1'b0;
                        status_next = bpa_pkg::STAT_OK;
                        state_next  = bpa_pkg::S_DONE;
                    end
                end
            end

            bpa_pkg::S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next              = 1'b1;
                    rsp_data_next.status        = status_reg;
                    rsp_data_next.alloc_address =
                        (cmd_reg == bpa_pkg::CMD_ALLOC && status_reg == bpa_pkg::STAT_OK)
                        ? base_reg + (AW'(start_reg) << PS) : '0;
                    rsp_data_next.pages_free    = free_reg;
                    rsp_data_next.pages_used    = managed_reg - free_reg;
                    state_next                  = bpa_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = bpa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bpa_pkg::S_IDLE;
            rsp_valid_reg <= 1'b0;
            dv_reg        <= 1'b0;
            cfg_base_reg  <= '0;
            cfg_limit_reg <= '0;
            base_reg      <= '0;
            managed_reg   <= '0;
            free_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            dv_reg        <= dv_next;
            cfg_base_reg  <= cfg_base_next;
            cfg_limit_reg <= cfg_limit_next;
            base_reg      <= base_next;
            managed_reg   <= managed_next;
            free_reg      <= free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_data_reg  <= rsp_data_next;
        cmd_reg       <= cmd_next;
        status_reg    <= status_next;
        n_reg         <= n_next;
        addr_reg      <= addr_next;
        run_reg       <= run_next;
        rd_word_reg   <= rd_word_next;
        last_word_reg <= last_word_next;
        dword_reg     <= dword_next;
        start_reg     <= start_next;
        end_reg       <= end_next;
    end

endmodule

// ===== src/bpa_checker.sv =====
// Port-level assertions for the page allocator and the bind that attaches them.
`timescale 1ns / 1ps

module bpa_checker #(
    parameter int MAX_PAGE_COUNT = 4096
) (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input bpa_pkg::rsp_item_t rsp_data
);

    logic [1:0] pending_reg;
    logic [1:0] pending_next;
    logic       req_fire;
    logic       rsp_fire;

    assign req_fire = req_valid && req_ready;
    assign rsp_fire = rsp_valid && rsp_ready;

    always_comb
    begin
        pending_next = pending_reg + 2'(req_fire) - 2'(rsp_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // A result that is not taken keeps its value.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("result changed while stalled");

    // Only a successful allocation carries an address.
    a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.status != bpa_pkg::STAT_OK |-> rsp_data.alloc_address == '0)
        else $error("address given with a failing status");

    // Free plus used pages is the managed page count, never above capacity.
    a_count_sum: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> 32'(rsp_data.pages_free) + 32'(rsp_data.pages_used) <= MAX_PAGE_COUNT)
        else $error("page counts exceed capacity");

    // Every result belongs to an accepted item, and at most two are in the block.
    a_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_fire |-> pending_reg != 2'd0) and (pending_reg <= 2'd2))
        else $error("result without a matching item");

endmodule

bind bitmap_page_allocator bpa_checker #(
    .MAX_PAGE_COUNT (MAX_PAGE_COUNT)
) u_bpa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

// ===== dv/bpa_result_check.sv =====
// Result checker for the bitmap page allocator: keeps its own page pool and compares results.
`timescale 1ns / 1ps

module bpa_result_check #(
    parameter int PAGE_CAPACITY = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic               req_ready,
    input  bpa_pkg::req_item_t req_data,
    input  logic               rsp_valid,
    input  logic               rsp_ready,
    input  bpa_pkg::rsp_item_t rsp_data,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  bpa_pkg::cfg_item_t cfg_data,
    output int                 fail_count,
    output int                 results_owed
);

    localparam int AW = bpa_pkg::ADDR_W;
    localparam int CW = bpa_pkg::CNT_W;
    localparam logic [CW-1:0] PAGE_CAP = CW'(PAGE_CAPACITY);

    // Register values as written, and the copies latched by the last initialize.
    logic [AW-1:0] reg_base;
    logic [CW-1:0] reg_limit;
    logic [AW-1:0] pool_base;
    logic [CW-1:0] pool_pages;
    logic [CW-1:0] pool_free;
    bit            page_busy [PAGE_CAPACITY];

    bpa_pkg::rsp_item_t pending_results [$];
    int                 results_seen;

    function automatic void log_failure(input string what);
        fail_count++;
        if (fail_count <= 10)
            $display("[%0t] %s", $time, what);
    endfunction

    function automatic bpa_pkg::rsp_item_t pool_command_result(
        input bpa_pkg::req_item_t cmd_item);
        bpa_pkg::rsp_item_t res;
        logic [CW-1:0]      n;
        logic [CW-1:0]      run_len;
        logic [AW-1:0]      offset;
        logic [AW-1:0]      run_addr;
        longint unsigned    start_pg;
        bit                 found;
        int                 i;
        int                 first;

        n = cmd_item.page_count_req;
        res.status = bpa_pkg::STAT_IGNORED;
        res.alloc_address = '0;
        unique case (cmd_item.command)
            bpa_pkg::CMD_INIT:
            begin
                pool_pages = (reg_limit > PAGE_CAP) ? PAGE_CAP : reg_limit;
                pool_base = reg_base;
                for (i = 0; i < PAGE_CAPACITY; i++)
                    page_busy[i] = (i >= pool_pages);
                pool_free = pool_pages;
                res.status = bpa_pkg::STAT_OK;
            end
            bpa_pkg::CMD_ALLOC:
            begin
                res.status = bpa_pkg::STAT_REFUSED;
                if (n != 0 && n <= pool_free)
                begin
                    run_len = '0;
                    found = 1'b0;
                    // First fit: the lowest run of n free pages wins.
                    for (i = 0; i < pool_pages && !found; i++)
                    begin
                        run_len = page_busy[i] ? '0 : run_len + 1'b1;
                        if (run_len == n)
                        begin
                            found = 1'b1;
                            first = i + 1 - n;
                            for (int k = first; k <= i; k++)
                                page_busy[k] = 1'b1;
                            pool_free = pool_free - n;
                            run_addr = AW'(first);
                            res.status = bpa_pkg::STAT_OK;
                            res.alloc_address = pool_base + (run_addr << bpa_pkg::PAGE_SHIFT);
                        end
                    end
                end
            end
            bpa_pkg::CMD_FREE:
            begin
                if (cmd_item.address != 0 && n != 0 && cmd_item.address >= pool_base)
                begin
                    offset = cmd_item.address - pool_base;
                    start_pg = offset >> bpa_pkg::PAGE_SHIFT;
                    if (start_pg < pool_pages && start_pg + n <= pool_pages)
                    begin
                        first = int'(start_pg);
                        for (i = first; i < first + n; i++)
                        begin
                            if (page_busy[i])
                            begin
                                page_busy[i] = 1'b0;
                                pool_free = pool_free + 1'b1;
                            end
                        end
                        res.status = bpa_pkg::STAT_OK;
                    end
                end
            end
            default:
                res.status = bpa_pkg::STAT_IGNORED;
        endcase
        res.pages_free = pool_free;
        res.pages_used = pool_pages - pool_free;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        bpa_pkg::rsp_item_t want;
        if (!rst_n)
        begin
            reg_base = '0;
            reg_limit = '0;
            pool_base = '0;
            pool_pages = '0;
            pool_free = '0;
            for (int p = 0; p < PAGE_CAPACITY; p++)
                page_busy[p] = 1'b1;
            pending_results.delete();
            results_seen = 0;
            fail_count = 0;
            results_owed = 0;
        end
        else
        begin
            // Results go first: a result never belongs to an item taken at the same edge.
            if (rsp_valid && rsp_ready)
            begin
                results_seen++;
                if (pending_results.size() == 0)
                    log_failure($sformatf("result %0d arrived with nothing expected",
                        results_seen));
                else
                begin
                    want = pending_results.pop_front();
                    if (rsp_data.status !== want.status ||
                        rsp_data.alloc_address !== want.alloc_address ||
                        rsp_data.pages_free !== want.pages_free ||
                        rsp_data.pages_used !== want.pages_used)
                        log_failure($sformatf({"result %0d: expected status %0d addr %h ",
                            "free %0d used %0d, got status %0d addr %h free %0d used %0d"},
                            results_seen, want.status, want.alloc_address,
                            want.pages_free, want.pages_used, rsp_data.status,
                            rsp_data.alloc_address, rsp_data.pages_free,
                            rsp_data.pages_used));
                end
            end
            // An item taken at this edge still sees the registers as they were before it.
            if (req_valid && req_ready)
                pending_results.push_back(pool_command_result(req_data));
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_data.index == bpa_pkg::REG_REGION_BASE)
                    reg_base = cfg_data.wdata;
                else
                    reg_limit = cfg_data.wdata[CW-1:0];
            end
            results_owed = pending_results.size();
        end
    end

endmodule

// ===== dv/tb_bitmap_page_allocator.sv =====
// Testbench top for the bitmap page allocator: clock, reset, stimulus and the final verdict.
`timescale 1ns / 1ps

module tb_bitmap_page_allocator;

    localparam int   AW            = bpa_pkg::ADDR_W;
    localparam int   CW            = bpa_pkg::CNT_W;
    localparam int   PAGE_CAPACITY = 4096;
    localparam int   ITEM_TARGET   = 1450;
    localparam int   SETTLE_CYCLES = 150;
    localparam int   HOLD_CYCLES   = 400;
    localparam bpa_pkg::cmd_t CMD_UNUSED = 2'd3;
    localparam logic [AW-1:0] TOP_PAGE = 48'hFFFF_FFFF_F000;
    localparam logic [AW-1:0] LOW_BASE = 48'h0000_0010_0000;

    logic clk;
    logic rst_n;

    bpa_stream_if #(.T(bpa_pkg::req_item_t)) req_if ();
    bpa_stream_if #(.T(bpa_pkg::rsp_item_t)) rsp_if ();
    bpa_stream_if #(.T(bpa_pkg::cfg_item_t)) cfg_if ();

    int result_errors;
    int results_owed;
    int items_sent;
    bit no_idle;
    bit hold_rsp;

    // Last region written; used to aim requests at sensible pages and to size each phase.
    logic [AW-1:0] aim_base;
    int            aim_pages;

    bitmap_page_allocator #(
        .MAX_PAGE_COUNT(PAGE_CAPACITY)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    bpa_result_check #(
        .PAGE_CAPACITY(PAGE_CAPACITY)
    ) result_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_if.valid),
        .req_ready    (req_if.ready),
        .req_data     (req_if.data),
        .rsp_valid    (rsp_if.valid),
        .rsp_ready    (rsp_if.ready),
        .rsp_data     (rsp_if.data),
        .cfg_valid    (cfg_if.valid),
        .cfg_ready    (cfg_if.ready),
        .cfg_data     (cfg_if.data),
        .fail_count   (result_errors),
        .results_owed (results_owed)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    initial
    begin
        #80_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic logic [AW-1:0] rand_addr();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[AW-1:0];
    endfunction

    // Mostly no gap or a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    task automatic send_req(input bpa_pkg::cmd_t op, input int count,
                            input logic [AW-1:0] addr);
        int                 gap;
        bpa_pkg::req_item_t item;
        gap = pick_gap();
        item.command = op;
        item.page_count_req = count[CW-1:0];
        item.address = addr;
        @(negedge clk);
        if (gap != 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= item;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic write_reg(input bpa_pkg::reg_idx_t idx, input logic [AW-1:0] value);
        bpa_pkg::cfg_item_t item;
        item.index = idx;
        item.wdata = value;
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= item;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Stops offering items and waits until every result is back.
    task automatic drain(input int settle);
        @(negedge clk);
        req_if.valid <= 1'b0;
        wait (results_owed == 0);
        repeat (settle) @(posedge clk);
    endtask

    task automatic configure(input logic [AW-1:0] base, input int limit);
        logic [AW-1:0] lim_word;
        drain(8);
        // Bits above the 13-bit limit field carry noise now and then.
        lim_word = ($urandom_range(0, 3) == 0) ? rand_addr() : '0;
        lim_word[CW-1:0] = limit[CW-1:0];
        if ($urandom_range(0, 1))
        begin
            write_reg(bpa_pkg::REG_REGION_BASE, base);
            write_reg(bpa_pkg::REG_PAGE_LIMIT, lim_word);
        end
        else
        begin
            write_reg(bpa_pkg::REG_PAGE_LIMIT, lim_word);
            write_reg(bpa_pkg::REG_REGION_BASE, base);
        end
        aim_base = base;
        aim_pages = (limit > PAGE_CAPACITY) ? PAGE_CAPACITY : limit;
    endtask

    // Response side: random stalls, plus one long hold when asked.
    initial
    begin : rsp_side
        int stall_left;
        stall_left = 0;
        rsp_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_rsp)
            begin
                hold_rsp = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            else if (stall_left == 0)
                stall_left = pick_gap();
            if (stall_left != 0)
            begin
                rsp_if.ready <= 1'b0;
                stall_left--;
            end
            else
                rsp_if.ready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        logic [AW-1:0] base;
        logic [AW-1:0] addr;
        logic [AW-1:0] page_addr;
        logic [31:0]   rnd;
        bpa_pkg::cmd_t op;
        int            phase;
        int            limit;
        int            span;
        int            sel;
        int            cnt;
        int            pg;
        int            room;

        rst_n <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.data <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.data <= '0;
        items_sent = 0;
        no_idle = 1'b0;
        hold_rsp = 1'b0;
        aim_base = '0;
        aim_pages = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Nothing is managed before the first initialize.
        send_req(bpa_pkg::CMD_ALLOC, 1, '0);
        send_req(bpa_pkg::CMD_FREE, 1, 48'h1000);
        send_req(CMD_UNUSED, 1, 48'h1000);

        configure(LOW_BASE, 8);
        send_req(bpa_pkg::CMD_INIT, 0, '0);
        send_req(bpa_pkg::CMD_ALLOC, 0, '0);
        send_req(bpa_pkg::CMD_ALLOC, 9, '0);
        send_req(bpa_pkg::CMD_ALLOC, 8, '0);
        send_req(bpa_pkg::CMD_ALLOC, 1, '0);
        send_req(bpa_pkg::CMD_FREE, 1, '0);
        send_req(bpa_pkg::CMD_FREE, 0, LOW_BASE);
        send_req(bpa_pkg::CMD_FREE, 1, LOW_BASE - 1);
        send_req(bpa_pkg::CMD_FREE, 1, LOW_BASE + 8 * 4096);
        send_req(bpa_pkg::CMD_FREE, 3, LOW_BASE + 6 * 4096);
        // Unaligned address: the offset within the page is dropped.
        send_req(bpa_pkg::CMD_FREE, 1, LOW_BASE + 4096 + 'h123);
        send_req(bpa_pkg::CMD_FREE, 1, LOW_BASE + 3 * 4096);
        send_req(bpa_pkg::CMD_FREE, 2, LOW_BASE + 5 * 4096);
        send_req(bpa_pkg::CMD_FREE, 1, LOW_BASE + 5 * 4096);
        // Four pages free, but no run of three.
        send_req(bpa_pkg::CMD_ALLOC, 3, '0);
        send_req(bpa_pkg::CMD_ALLOC, 2, '0);

        // New settings stay unused until the next initialize; the limit saturates.
        configure(TOP_PAGE, 8191);
        send_req(bpa_pkg::CMD_ALLOC, 1, '0);
        send_req(bpa_pkg::CMD_INIT, 8191, 48'hFFFF_FFFF_FFFF);
        send_req(bpa_pkg::CMD_ALLOC, 8191, '0);
        send_req(bpa_pkg::CMD_ALLOC, PAGE_CAPACITY, '0);
        send_req(bpa_pkg::CMD_FREE, 1, 48'hFFFF_FFFF_FFFF);
        send_req(bpa_pkg::CMD_INIT, 0, '0);
        send_req(bpa_pkg::CMD_ALLOC, 1, '0);
        // This run starts past the top of the address space and wraps to zero.
        send_req(bpa_pkg::CMD_ALLOC, 2, '0);
        send_req(bpa_pkg::CMD_FREE, 1, 48'h1000);

        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 2)
                base = '0;
            else if (sel < 4)
            begin
                page_addr = AW'($urandom_range(0, 40));
                base = TOP_PAGE - (page_addr << bpa_pkg::PAGE_SHIFT);
            end
            else
            begin
                base = rand_addr();
                if (sel < 7)
                    base[bpa_pkg::PAGE_SHIFT-1:0] = '0;
            end
            sel = $urandom_range(0, 19);
            if (sel == 0)
                limit = 0;
            else if (sel < 3)
                limit = $urandom_range(1024, 8191);
            else if (sel < 7)
                limit = $urandom_range(1, 8);
            else
                limit = $urandom_range(9, 256);
            if (phase == 2)
                limit = 32;
            if (phase == 3)
                limit = PAGE_CAPACITY;

            configure(base, limit);
            no_idle = (phase == 1) || ($urandom_range(0, 4) == 0);
            // One phase makes the block fill up behind a long response stall.
            if (phase == 2)
                hold_rsp = 1'b1;
            if (aim_pages == 0)
                span = 10;
            else if (aim_pages > 1024)
                span = 15;
            else
                span = $urandom_range(40, 120);

            send_req(bpa_pkg::CMD_INIT, $urandom_range(0, 8191), rand_addr());
            for (int j = 0; j < span; j++)
            begin
                sel = $urandom_range(0, 99);
                if (aim_pages == 0 || sel >= 90)
                begin
                    rnd = $urandom;
                    op = rnd[1:0];
                    addr = rnd[2] ? rand_addr() : aim_base + AW'(rnd[31:12]);
                    send_req(op, $urandom_range(0, 8191), addr);
                end
                else if (sel < 45)
                begin
                    sel = $urandom_range(0, 19);
                    if (sel == 0)
                        cnt = $urandom_range(0, 8191);
                    else if (sel < 3)
                        cnt = $urandom_range(0, aim_pages + 1);
                    else
                        cnt = $urandom_range(1, (aim_pages < 8) ? aim_pages : 8);
                    send_req(bpa_pkg::CMD_ALLOC, cnt, '0);
                end
                else if (sel < 87)
                begin
                    pg = $urandom_range(0, aim_pages - 1);
                    room = aim_pages - pg;
                    if ($urandom_range(0, 15) == 0)
                        cnt = $urandom_range(1, room + 2);
                    else
                        cnt = $urandom_range(1, (room < 8) ? room : 8);
                    page_addr = AW'(pg);
                    addr = aim_base + (page_addr << bpa_pkg::PAGE_SHIFT);
                    if ($urandom_range(0, 1))
                        addr = addr + AW'($urandom_range(0, 4095));
                    send_req(bpa_pkg::CMD_FREE, cnt, addr);
                end
                else
                    send_req(bpa_pkg::CMD_INIT, $urandom_range(0, 8191), rand_addr());
            end
            phase++;
        end

        no_idle = 1'b0;
        drain(SETTLE_CYCLES);
        if (result_errors == 0 && results_owed == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
